/* rtl/hbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg: shared constants and types for the Huffman bit stream decoder
// Defaults for the top-level parameters, field widths, register indexes,
// operation codes and the table scan status word.
// ----------------------------------------------------------------------------
package hbd_pkg;

  // defaults for top-level parameters
  localparam int TABLE_ENTRIES_DFLT = 128;
  localparam int CODE_BITS_DFLT     = 8;
  localparam int COUNT_BITS_DFLT    = 20;

  // fixed field widths
  localparam int SYM_BITS     = 7;
  localparam int IDX_BITS     = 7;
  localparam int IN_CODE_BITS = 8;
  localparam int BYTE_BITS    = 8;
  localparam int ECNT_BITS    = 8;
  localparam int MLEN_BITS    = 20;

  // stream word widths
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 8;

  // configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 20;
  localparam logic [CFG_AW-1:0] REG_ENTRY_COUNT    = 1'd0;
  localparam logic [CFG_AW-1:0] REG_MESSAGE_LENGTH = 1'd1;

  // operation codes (input tuser)
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // table scan result, returned once per scanned bit
  typedef struct packed {
    logic                done;  // one-cycle pulse: scan finished
    logic                hit;   // exactly one entry matched
    logic [SYM_BITS-1:0] sym;   // symbol of the matching entry
  } scan_status_t;

endpackage

/* rtl/huffman_bitstream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bitstream_decoder: bit-serial Huffman stream decoder
// Table loads and stream bytes arrive on one input stream; each byte is
// shifted out one bit per step and matched against the loaded code table.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+--------------------------------------
//   s_*      | in  | s_tvalid/s_tready  | tuser: operation; tdata: entry_index,
//            |     |                    | code_bits, symbol_value, data_byte
//   m_*      | out | m_tvalid/m_tready  | tdata: symbol; tlast: last_of_run;
//            |     |                    | tuser: message_done
//   cfg_*    | in  | cfg_we             | cfg_addr: register, cfg_wdata: value
//
// A load word is taken without leaving the idle state. For a data word,
// each bit is a full scan of N = min(entry_count, TABLE_ENTRIES) entries that
// reads one entry per cycle through the RAM read port. A finished message
// ends the word at once. rst is synchronous, active high; it clears control
// state and the decode position (the table is undefined until loaded).
// A stalled m_tready holds the scan at the next symbol; s_tready is high only
// between words, while the previous word's last symbol may still wait in the
// output register.
// ----------------------------------------------------------------------------
module huffman_bitstream_decoder #(
  parameter int TABLE_ENTRIES = hbd_pkg::TABLE_ENTRIES_DFLT,
  parameter int CODE_BITS     = hbd_pkg::CODE_BITS_DFLT,
  parameter int COUNT_BITS    = hbd_pkg::COUNT_BITS_DFLT
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [6:0] entry_index, [14:7] code_bits, [21:15] symbol_value,
  // [29:22] data_byte, [31:30] zero
  input  logic [hbd_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,   // [0] operation
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hbd_pkg::M_TDATA_W-1:0]  m_tdata,   // [6:0] symbol, [7] zero
  output logic                           m_tlast,   // last_of_run
  output logic                           m_tuser,   // [0] message_done
  // configuration
  input  logic                           cfg_we,
  input  logic [hbd_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [hbd_pkg::CFG_DW-1:0]     cfg_wdata
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam int OW = $clog2(CODE_BITS);
  localparam int BW = $clog2(hbd_pkg::BYTE_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_PUSH  = 6'b001000,
    ST_NEXT  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t state;

  // input fields
  logic [hbd_pkg::IDX_BITS-1:0]     in_index;
  logic [hbd_pkg::IN_CODE_BITS-1:0] in_code;
  logic [hbd_pkg::SYM_BITS-1:0]     in_sym;
  logic [hbd_pkg::BYTE_BITS-1:0]    in_byte;
  logic                             s_fire;

  assign in_index = s_tdata[6:0];
  assign in_code  = s_tdata[14:7];
  assign in_sym   = s_tdata[21:15];
  assign in_byte  = s_tdata[29:22];
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // configuration registers
  logic [hbd_pkg::ECNT_BITS-1:0] entry_count;
  logic [hbd_pkg::MLEN_BITS-1:0] message_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= hbd_pkg::ECNT_BITS'(1);
      message_length <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        hbd_pkg::REG_ENTRY_COUNT:    entry_count    <= cfg_wdata[hbd_pkg::ECNT_BITS-1:0];
        hbd_pkg::REG_MESSAGE_LENGTH: message_length <= cfg_wdata[hbd_pkg::MLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // entries taking part in matching, saturated to the table size
  logic [NW-1:0]         n_eff;
  logic [COUNT_BITS-1:0] limit;

  always_comb begin
    if (32'(entry_count) > TABLE_ENTRIES) begin
      n_eff = NW'(TABLE_ENTRIES);
    end else begin
      n_eff = NW'(entry_count);
    end
  end

  assign limit = COUNT_BITS'(message_length);

  // decode position
  logic [CODE_BITS-1:0]          partial;
  logic [OW-1:0]                 offset;
  logic [COUNT_BITS-1:0]         count;
  logic [hbd_pkg::BYTE_BITS-1:0] data_sr;   // byte shift register, LSB next
  logic [BW-1:0]                 bits_left;
  logic                          fin;
  logic [CODE_BITS-1:0]          pc_new;
  logic [CODE_BITS-1:0]          mask;

  assign fin = (count >= limit);

  // partial code with the current bit appended; mask covers bits 0..offset
  always_comb begin
    pc_new = partial | ({{(CODE_BITS-1){1'b0}}, data_sr[0]} << offset);
    for (int k = 0; k < CODE_BITS; k++) begin
      mask[k] = (k <= int'(offset));
    end
  end

  // table and scan unit
  hbd_pkg::scan_status_t status;
  logic                  tbl_we;

  assign tbl_we = s_fire && (s_tuser == hbd_pkg::OP_LOAD) &&
                  (32'(in_index) < TABLE_ENTRIES);

  hbd_matcher #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CODE_BITS     (CODE_BITS)
  ) u_matcher (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (tbl_we),
    .wr_addr   (AW'(in_index)),
    .wr_code   (CODE_BITS'(in_code)),
    .wr_sym    (in_sym),
    .start     (state == ST_START),
    .n_entries (n_eff),
    .pcode     (pc_new),
    .mask      (mask),
    .status    (status)
  );

  // one pending symbol is held back until it is known whether it ends the byte
  logic                         pend_valid;
  logic [hbd_pkg::SYM_BITS-1:0] pend_sym;
  logic                         pend_done;
  logic                         out_free;
  logic                         out_load;
  logic [hbd_pkg::SYM_BITS-1:0] out_sym;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = pend_valid && out_free && ((state == ST_PUSH) || (state == ST_FLUSH));
  assign m_tdata  = hbd_pkg::M_TDATA_W'(out_sym);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      partial    <= '0;
      offset     <= '0;
      count      <= '0;
      bits_left  <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // output register: loaded from the pending slot, cleared when taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_tuser == hbd_pkg::OP_LOAD) begin
              partial <= '0;
              offset  <= '0;
              count   <= '0;
            end else begin
              bits_left <= BW'(hbd_pkg::BYTE_BITS);
              if (!fin) begin
                state <= ST_START;
              end
            end
          end
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (status.done) begin
            bits_left <= bits_left - BW'(1);
            if (status.hit) begin
              partial <= '0;
              offset  <= '0;
              count   <= count + COUNT_BITS'(1);
              state   <= ST_PUSH;
            end else begin
              // overflow: drop the partial code after CODE_BITS misses
              if (offset == OW'(CODE_BITS - 1)) begin
                partial <= '0;
                offset  <= '0;
              end else begin
                partial <= pc_new;
                offset  <= offset + OW'(1);
              end
              state <= ST_NEXT;
            end
          end
        end
        ST_PUSH: begin
          if (!pend_valid) begin
            pend_valid <= 1'b1;
            state      <= ST_NEXT;
          end else if (out_free) begin
            m_tlast  <= 1'b0;
            m_tuser  <= pend_done;
            state    <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if ((bits_left == '0) || fin) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_START;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_tlast    <= 1'b1;
            m_tuser    <= pend_done;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_fire && (s_tuser == hbd_pkg::OP_DECODE)) begin
      data_sr <= in_byte;
    end else if ((state == ST_WAIT) && status.done) begin
      data_sr <= data_sr >> 1;
    end
    if ((state == ST_PUSH) && (!pend_valid || out_free)) begin
      pend_sym  <= status.sym;
      pend_done <= fin;
      if (pend_valid) begin
        out_sym <= pend_sym;
      end
    end
    if ((state == ST_FLUSH) && pend_valid && out_free) begin
      out_sym <= pend_sym;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a symbol that finishes the message always ends its byte's run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("message_done without last_of_run");

  // scan results arrive only while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.done |-> (state == ST_WAIT))
    else $error("scan finished outside wait state");

  // nothing is held back once the block is ready for the next word
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending symbol left behind at idle");

  // a scan start is always followed by the wait state
  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) |=> (state == ST_WAIT))
    else $error("scan start not followed by wait");

endmodule

/* rtl/hbd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hbd_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_matcher: code table store and serial match scan
// Holds code/symbol pairs in RAM. A start walks entries 0..n-1, one read per
// cycle, counts masked matches (saturating at two) and reports a unique hit.
// ----------------------------------------------------------------------------
module hbd_matcher #(
  parameter int TABLE_ENTRIES = hbd_pkg::TABLE_ENTRIES_DFLT,
  parameter int CODE_BITS     = hbd_pkg::CODE_BITS_DFLT
) (
  input  logic                               clk,
  input  logic                               rst,
  // table write
  input  logic                               wr_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
  input  logic [CODE_BITS-1:0]               wr_code,
  input  logic [hbd_pkg::SYM_BITS-1:0]       wr_sym,
  // scan request, operands held stable until done
  input  logic                               start,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] n_entries,
  input  logic [CODE_BITS-1:0]               pcode,
  input  logic [CODE_BITS-1:0]               mask,
  output hbd_pkg::scan_status_t              status
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW = CODE_BITS + hbd_pkg::SYM_BITS;

  logic                         busy;
  logic [NW-1:0]                idx;
  logic                         rd_v;
  logic                         rd_last;
  logic [1:0]                   cnt;
  logic [1:0]                   cnt_next;
  logic [hbd_pkg::SYM_BITS-1:0] sym_cap;
  logic [hbd_pkg::SYM_BITS-1:0] sym_next;
  logic [RW-1:0]                rdata;
  logic [CODE_BITS-1:0]         rd_code;
  logic [hbd_pkg::SYM_BITS-1:0] rd_sym;
  logic                         match;
  logic [NW-1:0]                n_m1;
  logic                         empty_start;
  logic                         scan_end;

  hbd_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({wr_sym, wr_code}),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_code     = rdata[CODE_BITS-1:0];
  assign rd_sym      = rdata[RW-1:CODE_BITS];
  assign match       = ((rd_code ^ pcode) & mask) == '0;
  assign n_m1        = n_entries - NW'(1);
  assign empty_start = start && (n_entries == '0);
  assign scan_end    = rd_v && rd_last;

  always_comb begin
    cnt_next = cnt;
    sym_next = sym_cap;
    if (rd_v && match) begin
      if (cnt == 2'd0) begin
        cnt_next = 2'd1;
        sym_next = rd_sym;
      end else begin
        cnt_next = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      idx         <= '0;
      rd_v        <= 1'b0;
      rd_last     <= 1'b0;
      cnt         <= 2'd0;
      status.done <= 1'b0;
      status.hit  <= 1'b0;
    end else begin
      cnt         <= start ? 2'd0 : cnt_next;
      rd_v        <= busy;
      rd_last     <= busy && (idx == n_m1);
      // empty table: nothing can match, report at once
      status.done <= empty_start || scan_end;
      if (empty_start) begin
        status.hit <= 1'b0;
      end else if (scan_end) begin
        status.hit <= (cnt_next == 2'd1);
      end
      if (start) begin
        idx <= '0;
        if (n_entries != '0) begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        idx <= idx + NW'(1);
        if (idx == n_m1) begin
          busy <= 1'b0;
        end
      end
      if (scan_end) begin
        status.sym <= sym_next;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    sym_cap <= sym_next;
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Huffman bit stream decoder
// A short directed table covers the corner cases (message limits, code
// overflow, ambiguous and unique matches, empty table), then random phases
// load a code table and stream bytes through it. Every decoded word is
// compared against its directed row's typed results or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SETTLE_CYCLES = 1200;    // settle time for the worst word, a full-table scan per bit
  localparam int DRAIN_LIMIT   = 50000;   // cycles allowed for results to drain

  // one input stream word, fields as the block sees them
  typedef struct {
    logic                             op;
    logic [hbd_pkg::IDX_BITS-1:0]     idx;
    logic [hbd_pkg::IN_CODE_BITS-1:0] code;
    logic [hbd_pkg::SYM_BITS-1:0]     sym;
    logic [hbd_pkg::BYTE_BITS-1:0]    data;
  } stream_word_t;

  // one decoded output word
  typedef struct packed {
    logic [hbd_pkg::SYM_BITS-1:0] sym;
    logic                         last;
    logic                         done;
  } sym_word_t;

  typedef enum int {ROW_REG, ROW_WORD} row_kind_t;

  // directed table row; n_typed < 0 means the model decides the results
  typedef struct {
    row_kind_t                    kind;
    logic [hbd_pkg::CFG_AW-1:0]   reg_sel;
    logic [hbd_pkg::CFG_DW-1:0]   reg_val;
    stream_word_t                 w;
    int                           n_typed;
    logic [hbd_pkg::SYM_BITS-1:0] typed_sym;
    logic                         typed_done;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [hbd_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = hbd_pkg::OP_LOAD;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [hbd_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tlast;
  logic                          m_tuser;
  logic                          cfg_we = 1'b0;
  logic [hbd_pkg::CFG_AW-1:0]    cfg_addr = hbd_pkg::REG_ENTRY_COUNT;
  logic [hbd_pkg::CFG_DW-1:0]    cfg_wdata = '0;

  // model state: table, decode position and register copies
  logic [hbd_pkg::IN_CODE_BITS-1:0] code_mem [hbd_pkg::TABLE_ENTRIES_DFLT];
  logic [hbd_pkg::SYM_BITS-1:0]     sym_mem  [hbd_pkg::TABLE_ENTRIES_DFLT];
  logic [hbd_pkg::IN_CODE_BITS-1:0] cur_code = '0;
  int                               bit_pos = 0;
  logic [hbd_pkg::MLEN_BITS-1:0]    sym_count = '0;
  logic [hbd_pkg::ECNT_BITS-1:0]    cfg_entries = 8'd1;
  logic [hbd_pkg::MLEN_BITS-1:0]    cfg_msg_len = '0;

  sym_word_t fresh_syms[$];     // results of the word just modeled
  sym_word_t pending_syms[$];   // results still owed by the block

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int words_sent    = 0;
  int loads_sent    = 0;
  int reg_writes    = 0;
  int syms_checked  = 0;

  huffman_bitstream_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("huffman_bitstream_decoder regression: fail");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // output checker: every accepted word must match the oldest expectation
  always @(posedge clk) begin
    sym_word_t got;
    sym_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[hbd_pkg::SYM_BITS-1:0], m_tlast, m_tuser};
      syms_checked++;
      if (pending_syms.size() == 0) begin
        note_failure($sformatf("unexpected word: sym %h last %b done %b",
                               got.sym, got.last, got.done));
      end else begin
        want = pending_syms.pop_front();
        if (got != want)
          note_failure($sformatf("want sym %h last %b done %b, got sym %h last %b done %b",
                                 want.sym, want.last, want.done,
                                 got.sym, got.last, got.done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  // slot whose code alone agrees with the gathered bits, or -1
  function automatic int match_slot();
    int n;
    int hit;
    logic [hbd_pkg::IN_CODE_BITS-1:0] mask;
    n    = (int'(cfg_entries) > hbd_pkg::TABLE_ENTRIES_DFLT) ?
           hbd_pkg::TABLE_ENTRIES_DFLT : int'(cfg_entries);
    mask = hbd_pkg::IN_CODE_BITS'((9'd1 << (bit_pos + 1)) - 9'd1);
    hit  = -1;
    for (int i = 0; i < n; i++) begin
      if (((code_mem[i] ^ cur_code) & mask) == '0) begin
        if (hit >= 0) return -1;
        hit = i;
      end
    end
    return hit;
  endfunction

  // advance the model by one word; symbols it yields land in fresh_syms
  function automatic void decode_word(input stream_word_t w);
    int hit;
    fresh_syms.delete();
    if (w.op == hbd_pkg::OP_LOAD) begin
      code_mem[w.idx] = w.code;
      sym_mem[w.idx]  = w.sym;
      cur_code  = '0;   // a load restarts decoding
      bit_pos   = 0;
      sym_count = '0;
    end else begin
      for (int b = 0; b < hbd_pkg::BYTE_BITS; b++) begin
        if (sym_count >= cfg_msg_len) break;   // message finished: rest ignored
        cur_code[bit_pos] = w.data[b];
        hit = match_slot();
        if (hit >= 0) begin
          sym_count++;
          fresh_syms.push_back('{sym_mem[hit], 1'b0, sym_count >= cfg_msg_len});
          cur_code = '0;
          bit_pos  = 0;
        end else begin
          bit_pos++;
          if (bit_pos >= hbd_pkg::IN_CODE_BITS) begin   // no code fits: drop the bits
            cur_code = '0;
            bit_pos  = 0;
          end
        end
      end
      if (fresh_syms.size() > 0) fresh_syms[$].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // all fields random; the ones the operation ignores stay as noise
  function automatic stream_word_t random_word(input logic op);
    stream_word_t w;
    w.op   = op;
    w.idx  = hbd_pkg::IDX_BITS'($urandom);
    w.code = hbd_pkg::IN_CODE_BITS'($urandom);
    w.sym  = hbd_pkg::SYM_BITS'($urandom);
    w.data = hbd_pkg::BYTE_BITS'($urandom);
    return w;
  endfunction

  function automatic dir_row_t row_reg(input logic [hbd_pkg::CFG_AW-1:0] sel,
                                       input logic [hbd_pkg::CFG_DW-1:0] val);
    dir_row_t r;
    r.kind    = ROW_REG;
    r.reg_sel = sel;
    r.reg_val = val;
    r.w       = random_word(hbd_pkg::OP_LOAD);
    r.n_typed = -1;
    r.typed_sym  = '0;
    r.typed_done = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t row_load(input logic [hbd_pkg::IDX_BITS-1:0] idx,
                                        input logic [hbd_pkg::IN_CODE_BITS-1:0] code,
                                        input logic [hbd_pkg::SYM_BITS-1:0] sym);
    dir_row_t r;
    r = row_reg(hbd_pkg::REG_ENTRY_COUNT, '0);
    r.kind    = ROW_WORD;
    r.w.idx   = idx;
    r.w.code  = code;
    r.w.sym   = sym;
    r.n_typed = 0;
    return r;
  endfunction

  // n_typed copies of sym, last on the final one, done there if asked
  function automatic dir_row_t row_data(input logic [hbd_pkg::BYTE_BITS-1:0] data,
                                        input int n_typed,
                                        input logic [hbd_pkg::SYM_BITS-1:0] sym,
                                        input logic done);
    dir_row_t r;
    r = row_reg(hbd_pkg::REG_ENTRY_COUNT, '0);
    r.kind       = ROW_WORD;
    r.w          = random_word(hbd_pkg::OP_DECODE);
    r.w.data     = data;
    r.n_typed    = n_typed;
    r.typed_sym  = sym;
    r.typed_done = done;
    return r;
  endfunction

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // present one word and hold it until the block takes it
  task automatic send_word(input stream_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.op;
    s_tdata  <= {2'b00, w.data, w.sym, w.code, w.idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (w.op == hbd_pkg::OP_LOAD) loads_sent++;
  endtask

  task automatic transfer(input stream_word_t w);
    send_word(w);
    decode_word(w);
    foreach (fresh_syms[i]) pending_syms.push_back(fresh_syms[i]);
  endtask

  // wait for every owed result, then for the block to finish its last word
  task automatic settle();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_syms.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_syms.size() != 0) begin
      note_failure($sformatf("%0d expected words never arrived", pending_syms.size()));
      pending_syms.delete();
    end
  endtask

  // register writes only happen with the block idle
  task automatic write_reg(input logic [hbd_pkg::CFG_AW-1:0] sel,
                           input logic [hbd_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == hbd_pkg::REG_ENTRY_COUNT) cfg_entries = val[hbd_pkg::ECNT_BITS-1:0];
    else cfg_msg_len = val[hbd_pkg::MLEN_BITS-1:0];
    reg_writes++;
  endtask

  // One random phase: program both registers, load every slot the scan will
  // touch, then stream bytes with the odd table reload mixed in. Half the
  // phases use fixed-length codes (slot number in the low bits, random above)
  // so long clean runs decode; the rest use raw random codes.
  task automatic run_phase(input int n_cfg, input int msg_len, input int n_bytes);
    int n_live;
    int mask;
    bit fixed_len;
    stream_word_t w;
    settle();
    write_reg(hbd_pkg::REG_ENTRY_COUNT, hbd_pkg::CFG_DW'(n_cfg));
    write_reg(hbd_pkg::REG_MESSAGE_LENGTH, hbd_pkg::CFG_DW'(msg_len));
    n_live    = (n_cfg > hbd_pkg::TABLE_ENTRIES_DFLT) ? hbd_pkg::TABLE_ENTRIES_DFLT : n_cfg;
    mask      = (1 << $clog2((n_live > 0) ? n_live : 1)) - 1;
    fixed_len = 1'($urandom_range(1));
    for (int i = 0; i < n_live; i++) begin
      w     = random_word(hbd_pkg::OP_LOAD);
      w.idx = hbd_pkg::IDX_BITS'(i);
      if (fixed_len)
        w.code = hbd_pkg::IN_CODE_BITS'((int'(w.code) & ~mask) | (i & mask));
      transfer(w);
    end
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(99) < 8) begin
        // reload mid-stream: breaks the run and restarts decoding
        w = random_word(hbd_pkg::OP_LOAD);
        if (n_live > 0) w.idx = hbd_pkg::IDX_BITS'($urandom_range(n_live - 1));
        transfer(w);
      end
      transfer(random_word(hbd_pkg::OP_DECODE));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t rows[$];

    // directed table; typed rows carry results readable straight off the spec
    rows.push_back(row_load(7'd0, 8'h00, 7'h41));
    rows.push_back(row_data(8'hFF, 0, 7'h00, 1'b0));      // zero-length message
    rows.push_back(row_reg(hbd_pkg::REG_MESSAGE_LENGTH, 20'd3));
    rows.push_back(row_data(8'h00, 3, 7'h41, 1'b1));      // stops after three
    rows.push_back(row_data(8'h00, 0, 7'h00, 1'b0));      // message already done
    rows.push_back(row_reg(hbd_pkg::REG_MESSAGE_LENGTH, 20'hFFFFF));
    rows.push_back(row_load(7'd0, 8'hFF, 7'h7F));
    rows.push_back(row_data(8'hFF, 8, 7'h7F, 1'b0));      // a symbol on every bit
    rows.push_back(row_data(8'h00, 0, 7'h00, 1'b0));      // eight misses: overflow
    rows.push_back(row_reg(hbd_pkg::REG_ENTRY_COUNT, 20'd2));
    rows.push_back(row_load(7'd1, 8'hFF, 7'h00));
    rows.push_back(row_data(8'hFF, 0, 7'h00, 1'b0));      // duplicate codes never resolve
    rows.push_back(row_load(7'd1, 8'h7F, 7'h00));
    rows.push_back(row_data(8'hFF, 1, 7'h7F, 1'b0));      // resolves on the eighth bit
    rows.push_back(row_data(8'h7F, 1, 7'h00, 1'b0));
    rows.push_back(row_data(8'h3C, -1, 7'h00, 1'b0));
    rows.push_back(row_load(7'd1, 8'h80, 7'h2A));         // one-bit codes, mixed symbols
    rows.push_back(row_data(8'hA5, -1, 7'h00, 1'b0));
    rows.push_back(row_data(8'h5A, -1, 7'h00, 1'b0));
    rows.push_back(row_reg(hbd_pkg::REG_ENTRY_COUNT, 20'd0));
    rows.push_back(row_data(8'hA5, 0, 7'h00, 1'b0));      // empty table matches nothing
    rows.push_back(row_reg(hbd_pkg::REG_ENTRY_COUNT, 20'd255));   // saturates to full table
    rows.push_back(row_reg(hbd_pkg::REG_ENTRY_COUNT, 20'd1));
    rows.push_back(row_data(8'h80, -1, 7'h00, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_idle(28, 67);
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_REG) begin
        settle();
        write_reg(rows[r].reg_sel, rows[r].reg_val);
      end else if (rows[r].n_typed < 0) begin
        transfer(rows[r].w);
      end else begin
        send_word(rows[r].w);
        decode_word(rows[r].w);   // keeps the model in step; typed values are checked
        for (int i = 0; i < rows[r].n_typed; i++)
          pending_syms.push_back('{rows[r].typed_sym, i == rows[r].n_typed - 1,
                                   rows[r].typed_done && (i == rows[r].n_typed - 1)});
      end
    end

    // random phases: sender mostly busy, receiver mostly stalled
    run_phase(4, 20'hFFFFF, 25);
    run_phase(16, 37, 25);
    run_phase(255, 20'hFFFFF, 12);   // every slot loaded, largest scan

    // sender mostly idle, receiver mostly ready
    set_idle(67, 28);
    run_phase(2, 20'hFFFFF, 25);
    run_phase(7, $urandom_range(20, 200), 25);
    run_phase(1, 20'hFFFFF, 25);

    // no idling on either side
    set_idle(0, 0);
    run_phase(12, 0, 5);
    run_phase(16, 20'hFFFFF, 30);
    run_phase(5, 1, 10);
    run_phase(6, $urandom_range(1000, 1 << 19), 8);

    settle();
    $display("run covered %0d stream words (%0d table loads) and %0d register writes",
             words_sent, loads_sent, reg_writes);
    $display("%0d decoded words checked, %0d mismatches", syms_checked, fail_count);
    if (fail_count == 0) begin
      $display("huffman_bitstream_decoder regression: pass");
    end else begin
      $display("huffman_bitstream_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* huffman_bitstream_decoder.f */
rtl/hbd_pkg.sv
rtl/hbd_ram.sv
rtl/hbd_matcher.sv
rtl/huffman_bitstream_decoder.sv
verif/tb_top.sv
